/* hw/rtl/rgb_to_yuv422_converter_unit_assert.svh */
// Assertion macros shared by the converter's checker.
// Needs nothing else; include by bare file name.
`ifndef RGB_TO_YUV422_CONVERTER_UNIT_ASSERT_SVH
`define RGB_TO_YUV422_CONVERTER_UNIT_ASSERT_SVH

// Checked only outside reset.
`define RGB2YUV422_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("rgb2yuv422 assertion failed");

// Checked on every edge, reset included.
`define RGB2YUV422_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("rgb2yuv422 assertion failed");

`endif

/* hw/rtl/rgb2yuv422_pkg.sv */
// Types and constants for the RGB to YUV 4:2:2 converter.
// No dependencies; used by the converter core and the top level.
`default_nettype none

package rgb2yuv422_pkg;

   localparam int SumW = 20;

   // BT.601 full-range coefficients, scaled by 1024
   localparam logic [SumW-1:0] K_Y_R = 20'd306;
   localparam logic [SumW-1:0] K_Y_G = 20'd601;
   localparam logic [SumW-1:0] K_Y_B = 20'd117;
   localparam logic [SumW-1:0] K_U_R = 20'd172;
   localparam logic [SumW-1:0] K_U_G = 20'd340;
   localparam logic [SumW-1:0] K_C_P = 20'd512;
   localparam logic [SumW-1:0] K_V_G = 20'd429;
   localparam logic [SumW-1:0] K_V_B = 20'd83;
   // 128 << 10, keeps the chroma sums non-negative
   localparam logic [SumW-1:0] CHROMA_BIAS = 20'd131072;
   localparam int FracW = 10;
   localparam logic [7:0] PIX_MAX = 8'd255;

   // red sits in the low byte, matching the req tdata layout
   typedef struct packed {
      logic [7:0] alpha;
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
   } pixel_type;

   typedef struct packed {
      logic [7:0] y;
      logic [7:0] u;
      logic [7:0] v;
   } yuv_type;

endpackage

`default_nettype wire

/* hw/rtl/rgb2yuv422_csc.sv */
// Color space conversion of one pixel, RGB to clamped Y, U, V.
// Depends on rgb2yuv422_pkg.
`default_nettype none

module rgb2yuv422_csc (
   input  rgb2yuv422_pkg::pixel_type pix,
   output rgb2yuv422_pkg::yuv_type   yuv
);
   import rgb2yuv422_pkg::*;

   logic [SumW-1:0] r_ext;
   logic [SumW-1:0] g_ext;
   logic [SumW-1:0] b_ext;
   logic [SumW-1:0] y_sum;
   logic [SumW-1:0] u_sum;
   logic [SumW-1:0] v_sum;

   function automatic logic [7:0] clamp_sum(input logic [SumW-1:0] s);
      logic [SumW-FracW-1:0] q;
      begin
         q = s[SumW-1:FracW];
         clamp_sum = (q > (SumW-FracW)'(PIX_MAX)) ? PIX_MAX : q[7:0];
      end
   endfunction

   assign r_ext = SumW'(pix.red);
   assign g_ext = SumW'(pix.green);
   assign b_ext = SumW'(pix.blue);

   assign y_sum = K_Y_R * r_ext + K_Y_G * g_ext + K_Y_B * b_ext;
   // biased sums never go negative, so the shift acts as a floor
   assign u_sum = K_C_P * b_ext + CHROMA_BIAS - K_U_R * r_ext - K_U_G * g_ext;
   assign v_sum = K_C_P * r_ext + CHROMA_BIAS - K_V_G * g_ext - K_V_B * b_ext;

   assign yuv.y = clamp_sum(y_sum);
   assign yuv.u = clamp_sum(u_sum);
   assign yuv.v = clamp_sum(v_sum);

endmodule

`default_nettype wire

/* hw/rtl/rgb_to_yuv422_converter_unit.sv */
// RGB to YUV 4:2:2 converter, top level.
// Depends on rgb2yuv422_pkg and rgb2yuv422_csc.
//
// req channel: one RGB(A) pixel per beat, tlast marks the last pixel of a row.
// rsp channel: one beat per pixel pair (Y0 U Y1 V plus both alphas), or one
//   beat for a lone odd pixel at the end of a row (tuser = 0, second-pixel
//   fields zero). The first pixel of a pair gives no beat.
// csr channel: writes alpha_present (bit 0); always ready. Write it only
//   while the block is idle. With alpha_present low both alphas read zero.
// Path: a pixel lands in the input register, is converted and paired
//   while it sits there, and its result is registered in the result
//   register that drives rsp.
// Throughput: one pixel per cycle while rsp is not stalled, in a single
//   pass from input register to result register.
// Stall: the result register holds while rsp_tready is low; the input
//   register still takes a beat, and first pixels of a pair keep moving into
//   the hold register. req_tready drops once a second or row-end pixel waits.
// Reset: synchronous; drops both valids and the held pixel, and sets
//   alpha_present to 1.
`default_nettype none

module rgb_to_yuv422_converter_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // red, green, blue, alpha_in
   input  logic        req_tlast,   // row_end
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // y_first, u_out, y_second, v_out,
                                    // alpha_first, alpha_second
   output logic        rsp_tuser,   // pair_valid
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_wdata
);
   import rgb2yuv422_pkg::*;

   logic      alpha_en_ff;
   logic      s1_valid_ff;
   logic      s1_valid_in;
   pixel_type s1_pix_ff;
   logic      s1_last_ff;

   logic      hold_ff;
   logic      hold_in;
   logic [7:0] held_y_ff;
   logic [7:0] held_u_ff;
   logic [7:0] held_v_ff;
   logic [7:0] held_a_ff;

   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic [47:0] rsp_data_ff;
   logic [47:0] rsp_data_in;
   logic       rsp_pair_ff;

   yuv_type    cur;
   logic       needs_slot;
   logic       rsp_free;
   logic       consume;
   logic       req_beat;
   logic [8:0] u_sum;
   logic [8:0] v_sum;
   logic [7:0] a_cur;
   logic [7:0] a_held;

   rgb2yuv422_csc u_csc (
      .pix (s1_pix_ff),
      .yuv (cur)
   );

   assign csr_ready  = 1'b1;
   assign needs_slot = hold_ff | s1_last_ff;
   assign rsp_free   = ~rsp_valid_ff | rsp_tready;
   assign consume    = s1_valid_ff & (~needs_slot | rsp_free);
   assign req_tready = ~s1_valid_ff | consume;
   assign req_beat   = req_tvalid & req_tready;

   assign u_sum  = {1'b0, held_u_ff} + {1'b0, cur.u};
   assign v_sum  = {1'b0, held_v_ff} + {1'b0, cur.v};
   assign a_cur  = alpha_en_ff ? s1_pix_ff.alpha : 8'd0;
   assign a_held = alpha_en_ff ? held_a_ff : 8'd0;

   always_comb begin
      s1_valid_in = req_beat | (s1_valid_ff & ~consume);
      hold_in     = hold_ff;
      if (consume) begin
         hold_in = ~needs_slot;
      end
      if (hold_ff) begin
         rsp_data_in = {a_cur, a_held, v_sum[8:1], cur.y, u_sum[8:1], held_y_ff};
      end else begin
         rsp_data_in = {8'd0, a_cur, 8'd0, 8'd0, cur.u, cur.y};
      end
      if (consume & needs_slot) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_en_ff  <= 1'b1;
         s1_valid_ff  <= 1'b0;
         hold_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            alpha_en_ff <= csr_wdata;
         end
         s1_valid_ff  <= s1_valid_in;
         hold_ff      <= hold_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_beat) begin
         s1_pix_ff  <= req_tdata;
         s1_last_ff <= req_tlast;
      end
      if (consume & ~needs_slot) begin
         held_y_ff <= cur.y;
         held_u_ff <= cur.u;
         held_v_ff <= cur.v;
         held_a_ff <= s1_pix_ff.alpha;
      end
      if (consume & needs_slot) begin
         rsp_data_ff <= rsp_data_in;
         rsp_pair_ff <= hold_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_pair_ff;

endmodule

`default_nettype wire

/* hw/rtl/rgb2yuv422_chk.sv */
// Port-level checker for the RGB to YUV 4:2:2 converter, bound to the top.
// Depends on rgb_to_yuv422_converter_unit_assert.svh.
`default_nettype none

module rgb2yuv422_chk (
   input wire        clock,
   input wire        reset,
   input wire        req_tvalid,
   input wire        req_tready,
   input wire        rsp_tvalid,
   input wire        rsp_tready,
   input wire [47:0] rsp_tdata,
   input wire        rsp_tuser
);
`include "rgb_to_yuv422_converter_unit_assert.svh"

   // a stalled result beat holds its payload
   `RGB2YUV422_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))

   // a lone pixel carries no second luma, V or second alpha
   `RGB2YUV422_ASSERT(a_lone_zero, clock, reset, rsp_tvalid && !rsp_tuser |-> rsp_tdata[47:40] == 8'd0 && rsp_tdata[31:16] == 16'd0)

   // reset empties the pipe: no result, input open
   `RGB2YUV422_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_tvalid && req_tready)

endmodule

bind rgb_to_yuv422_converter_unit rgb2yuv422_chk u_chk (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire

/* tb/rgb_to_yuv422_converter_unit_tb.sv */
// Testbench for rgb_to_yuv422_converter_unit: RGB(A) pixel rows in, YUV 4:2:2 beats out.
// Predicts each pair or lone-pixel beat in-line and checks it against the rsp stream.
// Depends on rgb2yuv422_pkg and the converter top level.
`timescale 1ns / 100ps

module rgb_to_yuv422_converter_unit_tb;
   import rgb2yuv422_pkg::*;

   localparam int DRAIN_CYCLES    = 6;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int MAX_PRINTED     = 40;

   typedef struct packed {
      logic [7:0] y_first;
      logic [7:0] u_out;
      logic [7:0] y_second;
      logic [7:0] v_out;
      logic [7:0] alpha_first;
      logic [7:0] alpha_second;
      logic       pair_valid;
   } yuv_beat_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;   // red, green, blue, alpha_in
   logic        req_tlast  = 1'b0; // row_end
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;         // y_first, u_out, y_second, v_out,
                                   // alpha_first, alpha_second
   logic        rsp_tuser;         // pair_valid
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic        csr_wdata  = 1'b0;

   // converter state as the testbench sees it
   bit         alpha_on = 1'b1;
   bit         pair_open;
   logic [7:0] held_luma, held_u, held_v, held_alpha;

   yuv_beat_type yuv_beats_due[$];

   int error_count, pixels_sent, pairs_due, lones_due, beats_checked, alpha_writes;
   int burst_left;
   bit gaps_on = 1'b1;

   // receiver stall pattern and long hold-off
   int hold_seq, hold_seen, hold_left, mode_left, stall_mode;

   rgb_to_yuv422_converter_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [7:0] clip_byte(input int x);
      if (x < 0) return 8'd0;
      if (x > 255) return 8'd255;
      return 8'(x);
   endfunction

   // BT.601 full range, coefficients x1024; chroma biased by 128<<10 so the
   // shift is a plain floor
   function automatic yuv_type rgb_to_yuv(input logic [7:0] r, g, b);
      int ri, gi, bi;
      yuv_type px;
      ri = r;
      gi = g;
      bi = b;
      px.y = clip_byte((306 * ri + 601 * gi + 117 * bi) >>> 10);
      px.u = clip_byte((512 * bi + 131072 - 172 * ri - 340 * gi) >>> 10);
      px.v = clip_byte((512 * ri + 131072 - 429 * gi - 83 * bi) >>> 10);
      return px;
   endfunction

   task automatic predict_pixel(input logic [7:0] r, g, b, a, input logic row_end);
      yuv_type      px;
      yuv_beat_type beat;
      px = rgb_to_yuv(r, g, b);
      if (pair_open) begin
         pair_open         = 1'b0;
         beat.y_first      = held_luma;
         beat.u_out        = 8'((int'(held_u) + int'(px.u)) >> 1);
         beat.y_second     = px.y;
         beat.v_out        = 8'((int'(held_v) + int'(px.v)) >> 1);
         beat.alpha_first  = alpha_on ? held_alpha : 8'd0;
         beat.alpha_second = alpha_on ? a : 8'd0;
         beat.pair_valid   = 1'b1;
         yuv_beats_due.push_back(beat);
         pairs_due++;
      end else if (row_end) begin
         beat.y_first      = px.y;
         beat.u_out        = px.u;
         beat.y_second     = 8'd0;
         beat.v_out        = 8'd0;
         beat.alpha_first  = alpha_on ? a : 8'd0;
         beat.alpha_second = 8'd0;
         beat.pair_valid   = 1'b0;
         yuv_beats_due.push_back(beat);
         lones_due++;
      end else begin
         // held alpha is kept whatever alpha_present says
         pair_open  = 1'b1;
         held_luma  = px.y;
         held_u     = px.u;
         held_v     = px.v;
         held_alpha = a;
      end
   endtask

   task automatic report_mismatch(input string what, input logic [47:0] got, want);
      error_count++;
      if (error_count <= MAX_PRINTED)
         $display("%0t: beat %0d %s: got %0h, want %0h", $time, beats_checked, what, got, want);
   endtask

   task automatic check_yuv_beat();
      yuv_beat_type got, want;
      got.y_first      = rsp_tdata[7:0];
      got.u_out        = rsp_tdata[15:8];
      got.y_second     = rsp_tdata[23:16];
      got.v_out        = rsp_tdata[31:24];
      got.alpha_first  = rsp_tdata[39:32];
      got.alpha_second = rsp_tdata[47:40];
      got.pair_valid   = rsp_tuser;
      if (yuv_beats_due.size() == 0) begin
         report_mismatch("arrived with nothing due", rsp_tdata, '0);
      end else begin
         want = yuv_beats_due.pop_front();
         if (got.y_first !== want.y_first)
            report_mismatch("y_first", 48'(got.y_first), 48'(want.y_first));
         if (got.u_out !== want.u_out)
            report_mismatch("u_out", 48'(got.u_out), 48'(want.u_out));
         if (got.y_second !== want.y_second)
            report_mismatch("y_second", 48'(got.y_second), 48'(want.y_second));
         if (got.v_out !== want.v_out)
            report_mismatch("v_out", 48'(got.v_out), 48'(want.v_out));
         if (got.alpha_first !== want.alpha_first)
            report_mismatch("alpha_first", 48'(got.alpha_first), 48'(want.alpha_first));
         if (got.alpha_second !== want.alpha_second)
            report_mismatch("alpha_second", 48'(got.alpha_second),
                            48'(want.alpha_second));
         if (got.pair_valid !== want.pair_valid)
            report_mismatch("pair_valid", 48'(got.pair_valid), 48'(want.pair_valid));
      end
      beats_checked++;
   endtask

   // rsp side: check accepted beats, then pick tready for the next cycle
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         check_yuv_beat();
      if (hold_seen != hold_seq) begin
         hold_seen = hold_seq;
         hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(32, 200);
         end
         mode_left--;
         case (stall_mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= 1'($urandom_range(0, 1));
            2: rsp_tready <= ($urandom_range(0, 7) != 0);
            default: rsp_tready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   // one req beat; tvalid stays up between back-to-back beats
   task automatic send_pixel(input logic [7:0] r, g, b, a, input logic row_end);
      if (gaps_on && burst_left == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = $urandom_range(1, 24);
      end
      if (burst_left != 0)
         burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= {a, b, g, r};
      req_tlast  <= row_end;
      do @(posedge clock); while (!req_tready);
      predict_pixel(r, g, b, a, row_end);
      pixels_sent++;
   endtask

   // a first pixel gives no beat, so let the pipe settle past the last one
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (yuv_beats_due.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_alpha_present(input bit enable);
      wait_idle();
      csr_valid <= 1'b1;
      csr_wdata <= enable;
      do @(posedge clock); while (!csr_ready);
      alpha_on = enable;
      alpha_writes++;
      csr_valid <= 1'b0;
   endtask

   function automatic logic [7:0] rand_level();
      case ($urandom_range(0, 7))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // primaries, black/white, odd row ends, pairs closed by row end;
   // runs on the reset value of alpha_present
   task automatic test_corner_pixels();
      send_pixel(8'd0, 8'd0, 8'd0, 8'd0, 1'b1);
      send_pixel(8'd255, 8'd255, 8'd255, 8'd255, 1'b1);
      send_pixel(8'd255, 8'd0, 8'd0, 8'h80, 1'b0);
      send_pixel(8'd0, 8'd255, 8'd0, 8'h7F, 1'b1);
      send_pixel(8'd0, 8'd0, 8'd255, 8'hAA, 1'b0);
      send_pixel(8'd255, 8'd255, 8'd0, 8'h55, 1'b0);
      send_pixel(8'd0, 8'd255, 8'd255, 8'h01, 1'b0);
      send_pixel(8'd255, 8'd0, 8'd255, 8'hFE, 1'b0);
      send_pixel(8'd16, 8'd128, 8'd240, 8'h0F, 1'b0);
      send_pixel(8'd240, 8'd128, 8'd16, 8'hF0, 1'b0);
      send_pixel(8'd128, 8'd128, 8'd128, 8'h33, 1'b1);
      send_pixel(8'd255, 8'd255, 8'd255, 8'h00, 1'b0);
      send_pixel(8'd0, 8'd0, 8'd0, 8'hFF, 1'b1);
      send_pixel(8'd1, 8'd2, 8'd3, 8'd4, 1'b1);
      send_pixel(8'd254, 8'd253, 8'd252, 8'd251, 1'b1);
   endtask

   // alpha_present is sampled when the pair goes out, not when its first
   // pixel is taken
   task automatic test_alpha_switch_held();
      send_pixel(8'd10, 8'd200, 8'd30, 8'hC3, 1'b0);
      write_alpha_present(1'b0);
      send_pixel(8'd90, 8'd60, 8'd250, 8'h3C, 1'b0);
      send_pixel(8'd77, 8'd0, 8'd255, 8'h99, 1'b1);
      send_pixel(8'd200, 8'd100, 8'd50, 8'hE7, 1'b0);
      write_alpha_present(1'b1);
      send_pixel(8'd5, 8'd250, 8'd128, 8'h18, 1'b1);
   endtask

   // mostly well-formed rows with random content; some rows carry random tlast
   task automatic test_random_rows(input int count);
      int   left, row_len, i;
      bit   noisy;
      logic row_end;
      left = count;
      while (left > 0) begin
         noisy   = ($urandom_range(0, 9) == 0);
         row_len = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16);
         for (i = 0; i < row_len && left > 0; i++) begin
            row_end = noisy ? 1'($urandom_range(0, 1)) : (i == row_len - 1);
            send_pixel(rand_level(), rand_level(), rand_level(), 8'($urandom_range(0, 255)),
                       row_end);
            left--;
         end
      end
   endtask

   // rsp held off while req keeps offering, so req_tready has to drop
   task automatic test_backpressure();
      int i;
      wait_idle();
      gaps_on = 1'b0;
      hold_seq <= hold_seq + 1;
      for (i = 0; i < 60; i++)
         send_pixel(rand_level(), rand_level(), rand_level(), 8'($urandom_range(0, 255)),
                    (i % 6) == 5);
      gaps_on = 1'b1;
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_corner_pixels();
      test_alpha_switch_held();
      test_random_rows(200);
      write_alpha_present(1'b0);
      test_random_rows(200);
      test_backpressure();
      write_alpha_present(1'b1);
      gaps_on = 1'b0;
      test_random_rows(180);
      gaps_on = 1'b1;
      write_alpha_present(1'b0);
      test_random_rows(90);
      write_alpha_present(1'b1);
      test_random_rows(90);

      wait_idle();
      $display("covered %0d pixels: %0d pairs and %0d lone row-end pixels checked",
               pixels_sent, pairs_due, lones_due);
      $display("alpha_present written %0d times, output held off for %0d cycles once",
               alpha_writes, HOLD_OFF_CYCLES);
      if (error_count == 0)
         $display("rgb_to_yuv422_converter_unit_tb: clean");
      else
         $display("rgb_to_yuv422_converter_unit_tb: errors");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("timeout with %0d beats still due", yuv_beats_due.size());
      $display("rgb_to_yuv422_converter_unit_tb: errors");
      $finish;
   end

endmodule

/* rgb_to_yuv422_converter_unit.f */
+incdir+hw/rtl
hw/rtl/rgb2yuv422_pkg.sv
hw/rtl/rgb2yuv422_csc.sv
hw/rtl/rgb_to_yuv422_converter_unit.sv
hw/rtl/rgb2yuv422_chk.sv
tb/rgb_to_yuv422_converter_unit_tb.sv
